FILE: hdl/wcfb_pkg.sv
// Shared types, constants and byte/CRC helpers for the wheel command frame builder.
// No dependencies.
`default_nettype none

package wcfb_pkg;

    // Input command codes
    localparam logic [2:0] FUNC_PING      = 3'd0;
    localparam logic [2:0] FUNC_INIT      = 3'd1;
    localparam logic [2:0] FUNC_TEST      = 3'd2;
    localparam logic [2:0] FUNC_SET_SPEED = 3'd3;
    localparam logic [2:0] FUNC_SET_TORQ  = 3'd4;
    localparam logic [2:0] FUNC_REQ_SPEED = 3'd5;
    localparam logic [2:0] FUNC_REQ_TORQ  = 3'd6;
    localparam logic [2:0] FUNC_UNUSED    = 3'd7;

    // Frame constants
    localparam logic [15:0] CRC_POLY    = 16'h8408;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [7:0]  CTRL_PING   = 8'h80;
    localparam logic [7:0]  CTRL_INIT   = 8'h01;
    localparam logic [7:0]  CTRL_APP    = 8'h08;
    localparam logic [7:0]  CTRL_TELEM  = 8'h87;
    localparam logic [7:0]  MODE_SPEED  = 8'h05;
    localparam logic [7:0]  MODE_TORQUE = 8'h16;
    localparam logic [7:0]  BODY_STD    = 8'h10;
    localparam logic [7:0]  BODY_TEST   = 8'h18;

    // Register map and reset values
    localparam logic [0:0] REG_DEST   = 1'b0;
    localparam logic [0:0] REG_SOURCE = 1'b1;
    localparam logic [7:0] DEST_RESET   = 8'h33;
    localparam logic [7:0] SOURCE_RESET = 8'h11;

    // Frame kinds decided by the front end
    typedef enum logic [2:0] {
        KIND_PING,
        KIND_INIT_LONG,
        KIND_INIT_SHORT,
        KIND_TEST,
        KIND_SET_SPEED,
        KIND_SET_TORQ,
        KIND_REQ_SPEED,
        KIND_REQ_TORQ
    } wcfb_kind_t;

    // One queued frame request
    typedef struct packed {
        wcfb_kind_t  kind;
        logic [31:0] value;
    } wcfb_desc_t;

    // Back-end status seen at the top level
    typedef struct packed {
        logic       busy;
        logic [3:0] pos;
    } wcfb_status_t;

    // Number of bytes covered by the CRC (addresses, control, body)
    function automatic logic [3:0] frame_len(input wcfb_kind_t kind);
        logic [3:0] len;
        case (kind)
            KIND_PING, KIND_INIT_LONG:  len = 4'd7;
            KIND_INIT_SHORT:            len = 4'd3;
            KIND_REQ_SPEED, KIND_REQ_TORQ: len = 4'd4;
            default:                    len = 4'd9;
        endcase
        return len;
    endfunction

    // Frame byte at a position below frame_len
    function automatic logic [7:0] frame_byte(input wcfb_kind_t kind,
                                              input logic [31:0] value,
                                              input logic [7:0] dest,
                                              input logic [7:0] src,
                                              input logic [3:0] pos);
        logic [7:0] b;
        logic       app;
        logic       req;
        app = (kind == KIND_TEST) || (kind == KIND_SET_SPEED) || (kind == KIND_SET_TORQ);
        req = (kind == KIND_REQ_SPEED) || (kind == KIND_REQ_TORQ);
        case (pos)
            4'd0: b = dest;
            4'd1: b = src;
            4'd2: begin
                if (kind == KIND_PING) b = CTRL_PING;
                else if (app)          b = CTRL_APP;
                else if (req)          b = CTRL_TELEM;
                else                   b = CTRL_INIT;
            end
            4'd3: begin
                if (kind == KIND_REQ_SPEED)     b = MODE_SPEED;
                else if (kind == KIND_REQ_TORQ) b = MODE_TORQUE;
                else                            b = 8'h00;
            end
            4'd4: begin
                if (kind == KIND_TEST)           b = BODY_TEST;
                else if (kind == KIND_SET_SPEED) b = MODE_SPEED;
                else if (kind == KIND_SET_TORQ)  b = MODE_TORQUE;
                else                             b = BODY_STD;
            end
            4'd5: b = app ? value[7:0]   : 8'h00;
            4'd6: b = app ? value[15:8]  : 8'h00;
            4'd7: b = value[23:16];
            4'd8: b = value[31:24];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Reflected CRC-16 over one byte, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
        logic [15:0] c;
        logic [7:0]  d;
        logic        fb;
        c = crc_in;
        d = data;
        for (int k = 0; k < 8; k++) begin
            fb = c[0] ^ d[0];
            c  = {1'b0, c[15:1]};
            if (fb) c = c ^ CRC_POLY;
            d  = {1'b0, d[7:1]};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/wheel_command_frame_builder.sv
// Top level of the wheel command frame builder: config registers, front end,
// request queue and byte serializer. Depends on wcfb_pkg, wcfb_front, wcfb_queue, wcfb_back.
//
//  Channel   Ports                            Beat
//  command   s_tvalid/s_tready/s_tdata        one command (func, value)
//  frame     m_tvalid/m_tready/m_tdata/m_tlast one frame byte, m_tlast on CRC high byte
//  config    cfg_we/cfg_index/cfg_wdata       one register write
//
// A frame of N bytes (5 to 11) leaves one byte per cycle while m_tready is high, from the
// back-end CRC step; consecutive frames follow back to back when the next
// request is already queued. On an idle block a command beat reaches m_tvalid through
// the queue write, the load into the serializer and the output register.
// Commands are taken while the request queue has room (QUEUE_DEPTH entries).
// aresetn is synchronous, active low; addresses return to 0x33 and 0x11.
// A stall on the frame side holds the output register and fills the queue.
`default_nettype none

module wheel_command_frame_builder
    import wcfb_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // [2:0] func, [34:3] value, [39:35] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [7:0]  cfg_wdata
);

    logic [7:0]   dest_reg;
    logic [7:0]   source_reg;
    logic         q_ready;
    logic         q_valid;
    logic         push;
    logic         pop;
    wcfb_desc_t   push_desc;
    wcfb_desc_t   q_desc;
    wcfb_status_t status;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dest_reg   <= DEST_RESET;
            source_reg <= SOURCE_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_DEST:   dest_reg   <= cfg_wdata;
                REG_SOURCE: source_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    wcfb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .func      (s_tdata[2:0]),
        .value     (s_tdata[34:3]),
        .q_ready   (q_ready),
        .push      (push),
        .push_desc (push_desc)
    );

    wcfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .q_ready   (q_ready),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_desc    (q_desc)
    );

    wcfb_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .dest_addr   (dest_reg),
        .source_addr (source_reg),
        .q_valid     (q_valid),
        .q_desc      (q_desc),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .out_byte    (m_tdata),
        .last_byte   (m_tlast),
        .status      (status)
    );

    // a full queue always has a head to offer
    a_full_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        !q_ready |-> q_valid)
        else $error("queue full but empty");

    // the unused selector never becomes a frame request
    a_unused_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tdata[2:0] == FUNC_UNUSED)) |-> !push)
        else $error("unused selector pushed");

    // the back end never runs past the CRC high byte
    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        status.busy |-> (status.pos <= 4'd10))
        else $error("frame position out of range");

    // no frame byte right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

`default_nettype wire

FILE: hdl/wcfb_front.sv
// Front end: accepts command beats, tracks the started flag, classifies frames.
// Depends on wcfb_pkg.
`default_nettype none

module wcfb_front
    import wcfb_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [2:0]  func,
    input  wire logic [31:0] value,
    input  wire logic        q_ready,
    output logic             push,
    output wcfb_desc_t       push_desc
);

    logic started_reg;
    logic started_next;
    logic accept;

    assign s_tready = q_ready;
    assign accept   = s_tvalid && s_tready;
    // unused selector is swallowed without a frame
    assign push     = accept && (func != FUNC_UNUSED);

    // classify the command
    always_comb begin
        started_next    = started_reg;
        push_desc.value = value;
        case (func)
            FUNC_PING:      push_desc.kind = KIND_PING;
            FUNC_INIT: begin
                push_desc.kind = started_reg ? KIND_INIT_SHORT : KIND_INIT_LONG;
                if (accept) started_next = !started_reg;
            end
            FUNC_TEST: begin
                push_desc.kind  = KIND_TEST;
                push_desc.value = 32'd0;
            end
            FUNC_SET_SPEED: push_desc.kind = KIND_SET_SPEED;
            FUNC_SET_TORQ:  push_desc.kind = KIND_SET_TORQ;
            FUNC_REQ_SPEED: push_desc.kind = KIND_REQ_SPEED;
            default:        push_desc.kind = KIND_REQ_TORQ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg <= 1'b0;
        end else begin
            started_reg <= started_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/wcfb_queue.sv
// Small FIFO of frame requests between front and back end.
// Depends on wcfb_pkg.
`default_nettype none

module wcfb_queue
    import wcfb_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push,
    input  wire wcfb_desc_t push_desc,
    output logic            q_ready,
    input  wire logic       pop,
    output logic            q_valid,
    output wcfb_desc_t      q_desc
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    wcfb_desc_t       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign q_ready = (count_reg != FULL_CNT);
    assign q_valid = (count_reg != '0);
    assign q_desc  = mem[rd_ptr_reg];
    assign do_push = push && q_ready;
    assign do_pop  = pop && q_valid;

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) mem[wr_ptr_reg] <= push_desc;
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)  rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)      count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push) count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/wcfb_back.sv
// Back end: serializes one frame a byte per cycle, unless the output stalls, with a running CRC-16.
// Depends on wcfb_pkg.
`default_nettype none

module wcfb_back
    import wcfb_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic [7:0] dest_addr,
    input  wire logic [7:0] source_addr,
    input  wire logic       q_valid,
    input  wire wcfb_desc_t q_desc,
    output logic            pop,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      out_byte,
    output logic            last_byte,
    output wcfb_status_t    status
);

    logic        busy_reg;
    wcfb_kind_t  kind_reg;
    logic [31:0] value_reg;
    logic [3:0]  pos_reg;
    logic [15:0] crc_reg;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;

    logic [3:0]  len;
    logic [3:0]  len_p1;
    logic        advance;
    logic        at_last;
    logic        in_body;
    logic [7:0]  cur_byte;

    assign len     = frame_len(kind_reg);
    assign len_p1  = len + 4'd1;
    assign in_body = (pos_reg < len);
    assign at_last = (pos_reg == len_p1);
    assign advance = busy_reg && (!out_valid_reg || m_tready);
    // next request loads as the current frame's final byte enters the output register
    assign pop     = q_valid && (!busy_reg || (advance && at_last));

    // byte select: body, then CRC low, then CRC high
    always_comb begin
        if (in_body)          cur_byte = frame_byte(kind_reg, value_reg, dest_addr,
                                                    source_addr, pos_reg);
        else if (pos_reg == len) cur_byte = crc_reg[7:0];
        else                  cur_byte = crc_reg[15:8];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            // output register
            if (advance) begin
                out_valid_reg <= 1'b1;
                out_byte_reg  <= cur_byte;
                out_last_reg  <= at_last;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            // frame sequencer
            if (pop) begin
                busy_reg  <= 1'b1;
                kind_reg  <= q_desc.kind;
                value_reg <= q_desc.value;
                pos_reg   <= 4'd0;
                crc_reg   <= CRC_INIT;
            end else if (advance) begin
                if (at_last) busy_reg <= 1'b0;
                pos_reg <= pos_reg + 4'd1;
                if (in_body) crc_reg <= crc_byte(crc_reg, cur_byte);
            end
        end
    end

    assign m_tvalid    = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_byte   = out_last_reg;
    assign status.busy = busy_reg;
    assign status.pos  = pos_reg;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking bench for wheel_command_frame_builder: commands in, frame bytes out.
// A scoreboard class predicts each frame and its CRC. Depends on wcfb_pkg and the RTL only.
`timescale 1ns / 100ps

module tb_top;
    import wcfb_pkg::*;

    localparam int          HOLD_OFF_CYCLES = 120;
    localparam int          QUIET_CYCLES    = 24;
    localparam logic [10:0] STALL_PATTERN   = 11'b10110111011;

    // Expected-frame store with its own copy of the address registers and init flag
    class frame_ledger;
        logic [7:0] dest_addr;
        logic [7:0] src_addr;
        bit         started;
        logic [8:0] expected_bytes[$];   // {last, byte}
        int         n_cmds, n_ignored, n_bytes, n_errors, n_long, n_short;

        function new();
            dest_addr = DEST_RESET;
            src_addr  = SOURCE_RESET;
            started   = 1'b0;
            n_cmds    = 0;
            n_ignored = 0;
            n_bytes   = 0;
            n_errors  = 0;
            n_long    = 0;
            n_short   = 0;
        endfunction

        function void set_reg(logic [0:0] idx, logic [7:0] data);
            if (idx == REG_DEST) dest_addr = data;
            else                 src_addr  = data;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        // Reflected CRC-16, data LSB first
        function logic [15:0] crc_update(logic [15:0] crc, logic [7:0] data);
            logic fb;
            for (int i = 0; i < 8; i++) begin
                fb  = crc[0] ^ data[i];
                crc = crc >> 1;
                if (fb) crc = crc ^ CRC_POLY;
            end
            return crc;
        endfunction

        // Build the frame for one accepted command and queue its bytes
        function void note_command(logic [2:0] cmd, logic [31:0] val);
            logic [7:0]  frm[$];
            logic [15:0] crc;
            logic [31:0] body;
            if (cmd == FUNC_UNUSED) begin
                n_ignored++;
                return;
            end
            n_cmds++;
            frm.push_back(dest_addr);
            frm.push_back(src_addr);
            case (cmd)
                FUNC_PING, FUNC_INIT: begin
                    frm.push_back(cmd == FUNC_PING ? CTRL_PING : CTRL_INIT);
                    // init toggles: short form when already started
                    if (cmd == FUNC_INIT && started) begin
                        started = 1'b0;
                        n_short++;
                    end else begin
                        if (cmd == FUNC_INIT) begin
                            started = 1'b1;
                            n_long++;
                        end
                        frm.push_back(8'h00);
                        frm.push_back(BODY_STD);
                        frm.push_back(8'h00);
                        frm.push_back(8'h00);
                    end
                end
                FUNC_TEST, FUNC_SET_SPEED, FUNC_SET_TORQ: begin
                    frm.push_back(CTRL_APP);
                    frm.push_back(8'h00);
                    if (cmd == FUNC_TEST)           frm.push_back(BODY_TEST);
                    else if (cmd == FUNC_SET_SPEED) frm.push_back(MODE_SPEED);
                    else                            frm.push_back(MODE_TORQUE);
                    // self test carries a zero value
                    body = (cmd == FUNC_TEST) ? 32'd0 : val;
                    frm.push_back(body[7:0]);
                    frm.push_back(body[15:8]);
                    frm.push_back(body[23:16]);
                    frm.push_back(body[31:24]);
                end
                default: begin
                    frm.push_back(CTRL_TELEM);
                    frm.push_back(cmd == FUNC_REQ_SPEED ? MODE_SPEED : MODE_TORQUE);
                end
            endcase
            crc = CRC_INIT;
            foreach (frm[i]) begin
                crc = crc_update(crc, frm[i]);
                expected_bytes.push_back({1'b0, frm[i]});
            end
            expected_bytes.push_back({1'b0, crc[7:0]});
            expected_bytes.push_back({1'b1, crc[15:8]});
        endfunction

        // Compare one output beat with the oldest expected byte
        function void check_byte(logic [7:0] data, logic last);
            logic [8:0] exp_beat;
            n_bytes++;
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected byte: actual data %02h last %0b", $time, data, last);
                n_errors++;
                return;
            end
            exp_beat = expected_bytes.pop_front();
            if (data !== exp_beat[7:0]) begin
                $display("%0t: byte mismatch: expected %02h actual %02h",
                         $time, exp_beat[7:0], data);
                n_errors++;
            end
            if (last !== exp_beat[8]) begin
                $display("%0t: tlast mismatch: expected %0b actual %0b",
                         $time, exp_beat[8], last);
                n_errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = REG_DEST;
    logic [7:0]  cfg_wdata = '0;

    bit          hold_off_req = 1'b0;
    bit          hold_off_done = 1'b0;
    frame_ledger ledger;

    wheel_command_frame_builder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Run limit
    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    // Output monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            ledger.check_byte(m_tdata, m_tlast);
    end

    // Frame sink: ready segments, fixed stall pattern, random stalls, one long hold-off
    initial begin : frame_sink
        int cyc;
        cyc = 0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (hold_off_req && !hold_off_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(posedge aclk);
                hold_off_done = 1'b1;
            end else begin
                case ((cyc / 150) % 3)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= STALL_PATTERN[cyc % 11];
                    default: m_tready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Offer one command and wait for the beat; s_tvalid stays high afterwards
    task automatic send_command(input logic [2:0] cmd, input logic [31:0] val);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, val, cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        ledger.note_command(cmd, val);
    endtask

    task automatic pause_sender(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic send_random_command();
        logic [2:0]  cmd;
        logic [31:0] val;
        if ($urandom_range(0, 11) == 0) cmd = FUNC_UNUSED;
        else cmd = FUNC_PING + 3'($urandom_range(0, FUNC_REQ_TORQ));
        case ($urandom_range(0, 7))
            0:       val = 32'd0;
            1:       val = 32'hFFFF_FFFF;
            default: val = $urandom;
        endcase
        send_command(cmd, val);
    endtask

    // Random bursts with random gaps; ends with valid low
    task automatic send_bursts(input int count);
        int left, burst, gap;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 8);
            if (burst > left) burst = left;
            repeat (burst) send_random_command();
            left -= burst;
            gap = $urandom_range(0, 5);
            if (gap != 0) pause_sender(gap);
        end
        pause_sender(1);
    endtask

    task automatic wait_for_frames();
        while (ledger.pending() != 0) @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    task automatic load_addresses(input logic [7:0] dest, input logic [7:0] src);
        cfg_we    <= 1'b1;
        cfg_index <= REG_DEST;
        cfg_wdata <= dest;
        @(posedge aclk);
        ledger.set_reg(REG_DEST, dest);
        cfg_index <= REG_SOURCE;
        cfg_wdata <= src;
        @(posedge aclk);
        ledger.set_reg(REG_SOURCE, src);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin : stimulus
        ledger = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (3) @(posedge aclk);

        // Directed frames at the reset addresses, back to back
        send_command(FUNC_PING,      32'd0);
        send_command(FUNC_INIT,      32'd0);          // long form, sets started
        send_command(FUNC_INIT,      32'hFFFF_FFFF);  // short form, clears started
        send_command(FUNC_INIT,      32'h1234_5678);  // long form again
        send_command(FUNC_TEST,      32'hFFFF_FFFF);  // value must not appear
        send_command(FUNC_SET_SPEED, 32'd0);
        send_command(FUNC_SET_SPEED, 32'hFFFF_FFFF);
        send_command(FUNC_SET_TORQ,  32'h1234_5678);
        send_command(FUNC_SET_TORQ,  32'h8000_0001);
        send_command(FUNC_REQ_SPEED, 32'hFFFF_FFFF);
        send_command(FUNC_REQ_TORQ,  32'd0);
        send_command(FUNC_UNUSED,    32'hFFFF_FFFF);  // ignored
        send_command(FUNC_PING,      32'hFFFF_FFFF);
        send_command(FUNC_INIT,      32'd0);          // short form
        send_command(FUNC_UNUSED,    32'd0);          // ignored
        send_command(FUNC_SET_SPEED, 32'hA5C3_0F96);
        send_command(FUNC_TEST,      32'd0);
        pause_sender(1);
        send_bursts(30);

        // Address extremes, then the long receiver hold-off under load
        wait_for_frames();
        load_addresses(8'h00, 8'hFF);
        send_bursts(20);
        hold_off_req = 1'b1;
        repeat (14) send_random_command();
        pause_sender(1);
        wait_for_frames();                            // sender idle until all frames out
        send_bursts(20);

        wait_for_frames();
        load_addresses(8'hFF, 8'h00);
        send_bursts(40);

        wait_for_frames();
        load_addresses(8'($urandom), 8'($urandom));
        send_bursts(20);

        wait_for_frames();
        $display("Run covered %0d frames (%0d long init, %0d short init), %0d ignored commands,",
                 ledger.n_cmds, ledger.n_long, ledger.n_short, ledger.n_ignored);
        $display("%0d bytes checked over four address settings with stalls on both sides.",
                 ledger.n_bytes);
        if (ledger.n_errors == 0 && ledger.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
